### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ERVE_ASSERT_IMP(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while dis is high.
`define ERVE_ASSERT_NXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### hw/rtl/erve_pkg.sv
// Shared types, constants and encode helpers for the event record encoder.
package erve_pkg;

   localparam logic [7:0] TypeCounter  = 8'h09;
   localparam logic [7:0] TypeActivity = 8'h0a;

   localparam int GroupsWidth  = 4;   // up to ten 7-bit groups
   localparam int BodyWidth    = 5;   // body is at most 30 bytes
   localparam int MaxTsGroups  = 10;
   localparam int FieldCount   = 5;
   localparam int DefaultQueueDepth = 2;

   // field order inside a record body
   localparam logic [2:0] FldTs     = 3'd0;
   localparam logic [2:0] FldCore   = 3'd1;
   localparam logic [2:0] FldCid    = 3'd2;
   localparam logic [2:0] FldValue  = 3'd3;
   localparam logic [2:0] FldThread = 3'd4;

   typedef struct packed {
      logic                                    op;
      logic [63:0]                             ts;
      logic [31:0]                             core;
      logic [31:0]                             cid;
      logic [31:0]                             value;
      logic [31:0]                             thread;
      logic [FieldCount-1:0][GroupsWidth-1:0]  groups;
      logic [BodyWidth-1:0]                    body;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [63:0] sext32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   // Number of 7-bit groups in the signed LEB128 form of v.
   function automatic logic [GroupsWidth-1:0] sleb_groups(input logic [63:0] v);
      logic signed [63:0]     t;
      logic [GroupsWidth-1:0] n;
      n = GroupsWidth'(MaxTsGroups);
      for (int i = MaxTsGroups - 1; i >= 1; i--) begin
         t = $signed(v) >>> (7 * i - 1);
         if (t == '0 || t == '1) begin
            n = GroupsWidth'(i);
         end
      end
      return n;
   endfunction

endpackage

### hw/rtl/erve_queue.sv
// Small entry queue between the classify front and the byte serializer.
module erve_queue #(
   parameter int Depth = erve_pkg::DefaultQueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  erve_pkg::entry_type        push_entry,
   input  logic                       pop,
   output erve_pkg::entry_type        head_entry,
   output erve_pkg::queue_status_type status
);
   import erve_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   entry_type               mem_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full      = (count_ff == CountWidth'(Depth));
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head_entry       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/erve_front.sv
// Front stage: takes events, drops failed timestamps, sizes each varint field.
module erve_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [63:0]                req_timestamp,
   input  logic [31:0]                req_core_index,
   input  logic [31:0]                req_counter_id,
   input  logic [31:0]                req_payload_value,
   input  logic [31:0]                req_thread_id,
   input  erve_pkg::queue_status_type q_status,
   output logic                       push,
   output erve_pkg::entry_type        push_entry
);
   import erve_pkg::*;

   logic       valid_ff, valid_in;
   entry_type  entry_ff, entry_in;
   logic       accept;
   logic       suppress;
   logic [GroupsWidth-1:0] thr_groups;

   assign busy     = valid_ff && q_status.full;
   assign accept   = start && !busy;
   assign suppress = (req_timestamp == '1);
   assign push     = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      entry_in        = entry_ff;
      entry_in.op     = req_operation;
      entry_in.ts     = req_timestamp;
      entry_in.core   = req_core_index;
      entry_in.cid    = req_counter_id;
      entry_in.value  = req_payload_value;
      entry_in.thread = req_thread_id;
      entry_in.groups[FldTs]     = sleb_groups(req_timestamp);
      entry_in.groups[FldCore]   = sleb_groups(sext32(req_core_index));
      entry_in.groups[FldCid]    = sleb_groups(sext32(req_counter_id));
      entry_in.groups[FldValue]  = sleb_groups(sext32(req_payload_value));
      entry_in.groups[FldThread] = sleb_groups(sext32(req_thread_id));
      thr_groups = req_operation ? entry_in.groups[FldThread] : '0;
      entry_in.body = BodyWidth'(entry_in.groups[FldTs])
                    + BodyWidth'(entry_in.groups[FldCore])
                    + BodyWidth'(entry_in.groups[FldCid])
                    + BodyWidth'(entry_in.groups[FldValue])
                    + BodyWidth'(thr_groups);
   end

   always_comb begin
      valid_in = valid_ff && q_status.full;
      if (accept) begin
         valid_in = !suppress;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### hw/rtl/erve_back.sv
// Back stage: serializes one queued record into bytes, one per cycle.
module erve_back (
   input  logic                       clock,
   input  logic                       reset,
   input  erve_pkg::queue_status_type q_status,
   input  erve_pkg::entry_type        head_entry,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_byte
);
   import erve_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_TYPE  = 4'b0010,
      ST_LEN   = 4'b0100,
      ST_FIELD = 4'b1000
   } back_state_type;

   back_state_type         state_ff, state_in;
   entry_type              rec_ff, rec_in;
   logic [1:0]             len_idx_ff, len_idx_in;
   logic [2:0]             fld_ff, fld_in;
   logic [GroupsWidth-1:0] grp_ff, grp_in;
   logic [63:0]            sh_ff, sh_in;
   logic                   strobe_ff, strobe_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic [2:0]             fld_next;
   logic [2:0]             fld_last;
   logic [63:0]            next_value;
   logic [GroupsWidth-1:0] next_groups;

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

   assign fld_next = fld_ff + 3'd1;
   assign fld_last = rec_ff.op ? FldThread : FldValue;

   always_comb begin
      case (fld_next)
         FldCore:   next_value = sext32(rec_ff.core);
         FldCid:    next_value = sext32(rec_ff.cid);
         FldValue:  next_value = sext32(rec_ff.value);
         FldThread: next_value = sext32(rec_ff.thread);
         default:   next_value = rec_ff.ts;
      endcase
      case (fld_next)
         FldCore:   next_groups = rec_ff.groups[FldCore];
         FldCid:    next_groups = rec_ff.groups[FldCid];
         FldValue:  next_groups = rec_ff.groups[FldValue];
         FldThread: next_groups = rec_ff.groups[FldThread];
         default:   next_groups = rec_ff.groups[FldTs];
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      rec_in     = rec_ff;
      len_idx_in = len_idx_ff;
      fld_in     = fld_ff;
      grp_in     = grp_ff;
      sh_in      = sh_ff;
      strobe_in  = 1'b0;
      byte_in    = byte_ff;
      last_in    = 1'b0;
      pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop      = 1'b1;
               rec_in   = head_entry;
               state_in = ST_TYPE;
            end
         end
         ST_TYPE: begin
            strobe_in  = 1'b1;
            byte_in    = rec_ff.op ? TypeActivity : TypeCounter;
            len_idx_in = '0;
            state_in   = ST_LEN;
         end
         ST_LEN: begin
            // little-endian length; only the low byte can be nonzero
            strobe_in  = 1'b1;
            byte_in    = (len_idx_ff == 2'd0) ? 8'(rec_ff.body) : 8'h00;
            len_idx_in = len_idx_ff + 2'd1;
            if (len_idx_ff == 2'd3) begin
               state_in = ST_FIELD;
               fld_in   = FldTs;
               sh_in    = rec_ff.ts;
               grp_in   = rec_ff.groups[FldTs];
            end
         end
         ST_FIELD: begin
            strobe_in = 1'b1;
            byte_in   = {grp_ff != GroupsWidth'(1), sh_ff[6:0]};
            sh_in     = 64'($signed(sh_ff) >>> 7);
            grp_in    = grp_ff - 1'b1;
            if (grp_ff == GroupsWidth'(1)) begin
               if (fld_ff == fld_last) begin
                  last_in = 1'b1;
                  // chain straight into the next record when one waits
                  if (q_status.not_empty) begin
                     pop      = 1'b1;
                     rec_in   = head_entry;
                     state_in = ST_TYPE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  fld_in = fld_next;
                  sh_in  = next_value;
                  grp_in = next_groups;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff     <= rec_in;
      len_idx_ff <= len_idx_in;
      fld_ff     <= fld_in;
      grp_ff     <= grp_in;
      sh_ff      <= sh_in;
      byte_ff    <= byte_in;
   end

endmodule

### hw/rtl/event_record_varint_encoder.sv
// Top level of the trace event record encoder.
//
// Each accepted event becomes one record on the byte channel: type byte
// (0x09 counter sample, 0x0a activity switch), 4-byte little-endian body
// length, then the timestamp and the 32-bit fields as signed LEB128, the
// thread only for activity switches. An event whose timestamp is all ones
// is accepted and dropped: no bytes.
// Output: one byte per cycle while rsp_strobe is high; rsp_last_byte marks
// the final byte. There is no backpressure on this side, so the receiver
// must take every strobed byte.
// Size: a record is N bytes; N is 9..30 for counter samples and 10..35
// for activity switches. A record already queued follows the one before
// directly, so sustained throughput is set by the single byte-wide
// serializer. Path from accept to the type byte in an empty block: front
// register, queue write, serializer pop, serializer output register.
// Buffering: the front register plus a QueueDepth-entry queue; busy goes
// high when both are full and drops once the serializer takes a record.
// A dropped event never reaches the queue.
module event_record_varint_encoder #(
   parameter int QueueDepth = erve_pkg::DefaultQueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   // item request
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [63:0] req_timestamp,
   input  logic [31:0] req_core_index,
   input  logic [31:0] req_counter_id,
   input  logic [31:0] req_payload_value,
   input  logic [31:0] req_thread_id,
   // byte stream
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);
   import erve_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push;
   logic             pop;

   // front: accept, suppress failed timestamps, size fields
   erve_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_timestamp     (req_timestamp),
      .req_core_index    (req_core_index),
      .req_counter_id    (req_counter_id),
      .req_payload_value (req_payload_value),
      .req_thread_id     (req_thread_id),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   // decoupling queue between front and serializer
   erve_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // back: byte serializer with registered outputs
   erve_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

### hw/rtl/erve_checker.sv
// Port-level checks on the record byte stream, bound to the top level.
`include "assert_macros.svh"

module erve_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_strobe,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);
   import erve_pkg::*;

   // nothing comes out in the cycle after reset
   `ERVE_ASSERT_NXT(a_quiet_after_reset, clock, 1'b0, reset, !rsp_strobe)

   // a record directly behind another starts with a type byte
   `ERVE_ASSERT_NXT(a_type_after_last, clock, reset, rsp_strobe && rsp_last_byte, !rsp_strobe || rsp_out_byte == TypeCounter || rsp_out_byte == TypeActivity)

   // the first byte after a gap is a type byte
   `ERVE_ASSERT_IMP(a_type_after_gap, clock, reset, !rsp_strobe ##1 rsp_strobe, rsp_out_byte == TypeCounter || rsp_out_byte == TypeActivity)

   // the closing varint byte carries no continuation bit
   `ERVE_ASSERT_IMP(a_last_no_cont, clock, reset, rsp_last_byte, rsp_strobe && !rsp_out_byte[7])

endmodule

bind event_record_varint_encoder erve_checker u_erve_checker (.*);

### test/event_record_varint_encoder_tb.sv
// Self-checking testbench for the trace event record encoder.
module event_record_varint_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // record kind on req_operation
   localparam logic OpCounter  = 1'b0;
   localparam logic OpActivity = 1'b1;

   // cycles with no accepted item and no strobed byte before the run is declared hung;
   // the longest legal quiet stretch is a long sender gap plus the encoder pipe
   localparam int IdleLimit  = 3000;
   // quiet cycles after the last expected byte, to catch stray output
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rec_byte_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [63:0] req_timestamp;
   logic [31:0] req_core_index;
   logic [31:0] req_counter_id;
   logic [31:0] req_payload_value;
   logic [31:0] req_thread_id;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;

   rec_byte_type pending_bytes[$];  // bytes still owed by the block, oldest first
   logic [7:0]   record_body[$];    // scratch: varint body of the record being built
   int           fail_count;
   int           idle_cycles;
   bit           no_idle;           // suppress sender gaps for a burst

   event_record_varint_encoder uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_timestamp     (req_timestamp),
      .req_core_index    (req_core_index),
      .req_counter_id    (req_counter_id),
      .req_payload_value (req_payload_value),
      .req_thread_id     (req_thread_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_byte     (rsp_last_byte)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Record predictor
   // ---------------------------------------------------------------

   function automatic logic [63:0] widen32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   // Signed LEB128: 7 bits per group, low first; stop once the remaining
   // value is pure sign and matches bit 6 of the group just taken.
   function automatic void append_sleb(input logic [63:0] v);
      logic [63:0] rest;
      logic [7:0]  grp;
      bit          done;
      rest = v;
      done = 1'b0;
      while (!done) begin
         grp  = {1'b0, rest[6:0]};
         rest = {{7{rest[63]}}, rest[63:7]};
         if ((rest == '0 && !grp[6]) || (rest == '1 && grp[6])) begin
            done = 1'b1;
         end else begin
            grp[7] = 1'b1;
         end
         record_body.push_back(grp);
      end
   endfunction

   // Queue the bytes of one accepted event. A failed time source (all-ones
   // stamp) yields nothing; thread only goes into activity records.
   function automatic void predict_record(input logic op, input logic [63:0] ts,
                                          input logic [31:0] core, input logic [31:0] cid,
                                          input logic [31:0] value, input logic [31:0] thread);
      logic [31:0] body_len;
      if (ts == '1) return;
      record_body.delete();
      append_sleb(ts);
      append_sleb(widen32(core));
      append_sleb(widen32(cid));
      append_sleb(widen32(value));
      if (op == OpActivity) append_sleb(widen32(thread));
      body_len = record_body.size();
      pending_bytes.push_back(rec_byte_type'{
         data: (op == OpActivity) ? erve_pkg::TypeActivity : erve_pkg::TypeCounter,
         last: 1'b0});
      // length is little endian over four bytes
      for (int i = 0; i < 4; i++) begin
         pending_bytes.push_back(rec_byte_type'{data: body_len[8*i +: 8], last: 1'b0});
      end
      foreach (record_body[i]) begin
         pending_bytes.push_back(rec_byte_type'{data: record_body[i],
                                                last: (i == record_body.size() - 1)});
      end
   endfunction

   // ---------------------------------------------------------------
   // Byte checker: the receiver can't stall, so every strobe is a byte.
   // Outputs are read in the active region of the edge, i.e. before the
   // block's own updates for that edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rec_byte_type want;
      if (!reset && rsp_strobe) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, got %02h last %0b",
                     $time, rsp_out_byte, rsp_last_byte);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte mismatch: expected %02h, got %02h",
                        $time, want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_byte !== want.last) begin
               $display("%0t: last_byte mismatch: expected %0b, got %0b",
                        $time, want.last, rsp_last_byte);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: any accepted item or strobed byte counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("%0t: timeout, %0d bytes still pending", $time, pending_bytes.size());
         $display("event_record_varint_encoder_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Mix of full-range, small positive and small negative words so the
   // varints take every length from 1 to 5 groups.
   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 3))
         0: w = w >> $urandom_range(0, 31);
         1: w = ~(w >> $urandom_range(0, 31));
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [63:0] rand_stamp();
      logic [63:0] s;
      s = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: s = s >> $urandom_range(0, 63);
         1: s = ~(s >> $urandom_range(0, 63));
         default: ;
      endcase
      if ($urandom_range(0, 15) == 0) s = '1;  // time source failure now and then
      return s;
   endfunction

   // Present one item and hold it until the block takes it. start stays
   // high after acceptance so that back-to-back items never see it drop and
   // rise in one step; the next call lowers it only if it idles first.
   task automatic send_event(input logic op, input logic [63:0] ts,
                             input logic [31:0] core, input logic [31:0] cid,
                             input logic [31:0] value, input logic [31:0] thread);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_operation     <= op;
      req_timestamp     <= ts;
      req_core_index    <= core;
      req_counter_id    <= cid;
      req_payload_value <= value;
      req_thread_id     <= thread;
      do @(posedge clock); while (busy);
      predict_record(op, ts, core, cid, value, thread);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Varint length boundaries and sign extremes on every field, both kinds.
   task automatic test_field_extremes();
      logic [63:0] stamps[12];
      logic [31:0] words[8];
      stamps = '{64'd0, 64'h3f, 64'h40, 64'hffff_ffff_ffff_ffc0, 64'hffff_ffff_ffff_ffbf,
                 64'h1fff, 64'h2000, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                 64'hffff_ffff_ffff_fffe, 64'h003f_ffff_ffff_ffff, 64'h0040_0000_0000_0000};
      words  = '{32'd0, 32'h3f, 32'h40, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                 32'hffff_ffc0, 32'h0800_0000};
      for (int i = 0; i < 12; i++) begin
         send_event(i[0] ? OpActivity : OpCounter, stamps[i], words[i % 8],
                    words[(i + 3) % 8], words[(i + 5) % 8], words[(i + 6) % 8]);
      end
      // all-longest records back to back
      no_idle = 1'b1;
      send_event(OpActivity, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff);
      send_event(OpCounter, 64'h7fff_ffff_ffff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h0);
      no_idle = 1'b0;
   endtask

   // All-ones stamp: item is taken but no bytes follow; mixed in between
   // real records and back to back.
   task automatic test_failed_time_source();
      send_event(OpCounter, '1, 32'd1, 32'd2, 32'd3, 32'd4);
      send_event(OpActivity, '1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      no_idle = 1'b1;
      send_event(OpActivity, 64'd1000, 32'd5, 32'd6, 32'd7, 32'd8);
      send_event(OpCounter, '1, 32'd0, 32'd0, 32'd0, 32'd0);
      send_event(OpActivity, '1, 32'd9, 32'd9, 32'd9, 32'd9);
      send_event(OpCounter, 64'd2000, 32'd10, 32'd11, 32'd12, 32'd13);
      no_idle = 1'b0;
   endtask

   // Counter samples must not encode the thread, whatever it holds.
   task automatic test_unused_thread();
      send_event(OpCounter, 64'd77, 32'd3, 32'd4, 32'd5, 32'd0);
      send_event(OpCounter, 64'd77, 32'd3, 32'd4, 32'd5, 32'hffff_ffff);
      send_event(OpCounter, 64'd77, 32'd3, 32'd4, 32'd5, $urandom);
   endtask

   // Random events; every so often a burst with no sender idling.
   task automatic test_random_events(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 16 == 0) no_idle = ($urandom_range(0, 2) == 0);
         send_event($urandom_range(0, 1) ? OpActivity : OpCounter, rand_stamp(),
                    rand_word(), rand_word(), rand_word(), rand_word());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      fail_count        = 0;
      no_idle           = 1'b0;
      reset             = 1'b1;
      start             = 1'b0;
      req_operation     = OpCounter;
      req_timestamp     = '0;
      req_core_index    = '0;
      req_counter_id    = '0;
      req_payload_value = '0;
      req_thread_id     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_failed_time_source();
      test_unused_thread();
      test_random_events(80);

      start <= 1'b0;
      // the watchdog ends the run if bytes stop coming
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0) begin
         $display("event_record_varint_encoder_tb OK");
      end else begin
         $display("event_record_varint_encoder_tb NOT OK");
      end
      $finish;
   end

endmodule
